>>> rtl/alu_with_condition_flags_defines.svh
// assertion macros for the alu with condition flags
// used by the port checker; no other dependencies
`ifndef ALU_WITH_CONDITION_FLAGS_DEFINES_SVH
`define ALU_WITH_CONDITION_FLAGS_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ALUF_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("alu port check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define ALUF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("alu port check failed");

`endif

>>> rtl/aluf_pkg.sv
// shared types, opcodes and helpers for the alu with condition flags
// no dependencies
package aluf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned CntW  = $clog2(DataW + 1);

  typedef enum logic [4:0] {
    K_MOV = 5'd0, K_ADD = 5'd1, K_SUB = 5'd2, K_MUL = 5'd3, K_DIV = 5'd4,
    K_CMP = 5'd5, K_AND = 5'd6, K_OR = 5'd7, K_XOR = 5'd8, K_SWAP = 5'd9,
    K_SHL = 5'd10, K_SHR = 5'd11, K_SAR = 5'd12, K_LDL = 5'd13, K_LDH = 5'd14,
    K_NOT = 5'd15, K_JMP = 5'd16, K_JP = 5'd17, K_JN = 5'd18, K_JZ = 5'd19,
    K_JC = 5'd20, K_JV = 5'd21, K_JNP = 5'd22, K_JNN = 5'd23, K_JNZ = 5'd24
  } kind_e;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0,
    FLT_IMM  = 2'd1,
    FLT_DIV0 = 2'd2
  } fault_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // one result item
  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic [DataW-1:0] second_value;
    logic             write_first;
    logic             write_second;
    logic             jump_taken;
    logic [3:0]       flags;
    fault_e           fault;
  } res_t;

  // status from the serial multiply/divide unit
  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic             c;
    logic             v;
    logic             is_div;
  } md_res_t;

  // {N, Z} of a stored result
  function automatic logic [1:0] nz_of(input logic [DataW-1:0] r);
    nz_of = {r[DataW-1], (r == '0)};
  endfunction

endpackage

>>> rtl/aluf_basic.sv
// combinational datapath: fault checks, moves, add/sub, logic, shifts, loads, jumps
// depends on aluf_pkg
module aluf_basic import aluf_pkg::*; (
  input  logic [4:0]       kind_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  input  logic             dimm_i,
  input  logic             simm_i,
  input  logic [3:0]       flags_i,
  output res_t             res_o,
  output logic             is_long_o
);

  logic [DataW:0]     sum, diff;
  logic [CntW-1:0]    n;
  logic [2*DataW-1:0] shl_w, shr_w, sar_w, lmask;
  logic               lost;
  logic [1:0]         nzc;
  kind_e              k;

  // shift count saturates at the word width
  assign n     = (b_i >= DataW) ? CntW'(DataW) : b_i[CntW-1:0];
  assign shl_w = {{DataW{1'b0}}, a_i} << n;
  assign shr_w = {{DataW{1'b0}}, a_i} >> n;
  assign sar_w = {{DataW{a_i[DataW-1]}}, a_i} >> n;
  assign lmask = ~({(2*DataW){1'b1}} << n);
  assign lost  = |(a_i & lmask[DataW-1:0]);
  assign sum   = {1'b0, a_i} + {1'b0, b_i};
  assign diff  = {1'b0, a_i} - {1'b0, b_i};
  assign nzc   = flags_i[3:2];
  assign k     = kind_e'(kind_i);

  always_comb begin
    res_o       = '0;
    res_o.flags = flags_i;
    res_o.fault = FLT_NONE;
    is_long_o   = 1'b0;
    priority if (kind_i <= K_NOT && kind_i != K_CMP &&
                 (dimm_i || (kind_i == K_SWAP && simm_i))) begin
      res_o.fault = FLT_IMM;
    end else if (kind_i == K_DIV && b_i == '0) begin
      res_o.fault = FLT_DIV0;
    end else begin
      unique case (k)
        K_MOV: begin
          res_o.result_value = b_i;
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(b_i), 2'b00};
        end
        K_ADD: begin
          res_o.result_value = sum[DataW-1:0];
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(sum[DataW-1:0]), sum[DataW],
            ((a_i[DataW-1] ^ sum[DataW-1]) & (b_i[DataW-1] ^ sum[DataW-1]))};
        end
        K_SUB, K_CMP: begin
          res_o.result_value = (k == K_SUB) ? diff[DataW-1:0] : '0;
          res_o.write_first  = (k == K_SUB);
          res_o.flags        = {nz_of(diff[DataW-1:0]), diff[DataW],
            ((a_i[DataW-1] ^ b_i[DataW-1]) & (a_i[DataW-1] ^ diff[DataW-1]))};
        end
        K_MUL, K_DIV: begin
          is_long_o = 1'b1;
        end
        K_AND: begin
          res_o.result_value = a_i & b_i;
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(a_i & b_i), 2'b00};
        end
        K_OR: begin
          res_o.result_value = a_i | b_i;
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(a_i | b_i), 2'b00};
        end
        K_XOR: begin
          res_o.result_value = a_i ^ b_i;
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(a_i ^ b_i), 2'b00};
        end
        K_SWAP: begin
          res_o.result_value = b_i;
          res_o.second_value = a_i;
          res_o.write_first  = 1'b1;
          res_o.write_second = 1'b1;
          res_o.flags        = {nz_of(b_i), 2'b00};
        end
        K_SHL: begin
          res_o.result_value = shl_w[DataW-1:0];
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(shl_w[DataW-1:0]), (|shl_w[2*DataW-1:DataW]),
                                (a_i[DataW-1] ^ shl_w[DataW-1])};
        end
        K_SHR: begin
          res_o.result_value = shr_w[DataW-1:0];
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(shr_w[DataW-1:0]), lost, 1'b0};
        end
        K_SAR: begin
          res_o.result_value = sar_w[DataW-1:0];
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(sar_w[DataW-1:0]), lost, 1'b0};
        end
        K_LDL: begin
          res_o.result_value = {a_i[DataW-1:HalfW], b_i[HalfW-1:0]};
          res_o.write_first  = 1'b1;
        end
        K_LDH: begin
          res_o.result_value = {b_i[HalfW-1:0], a_i[HalfW-1:0]};
          res_o.write_first  = 1'b1;
        end
        K_NOT: begin
          res_o.result_value = ~a_i;
          res_o.write_first  = 1'b1;
          res_o.flags        = {nz_of(~a_i), 2'b00};
        end
        K_JMP, K_JP, K_JN, K_JZ, K_JC, K_JV, K_JNP, K_JNN, K_JNZ: begin
          res_o.result_value = a_i;
          unique case (k)
            K_JMP:   res_o.jump_taken = 1'b1;
            K_JP:    res_o.jump_taken = (nzc == 2'b00);
            K_JN:    res_o.jump_taken = (nzc == 2'b10);
            K_JZ:    res_o.jump_taken = (nzc == 2'b01);
            K_JC:    res_o.jump_taken = flags_i[1];
            K_JV:    res_o.jump_taken = flags_i[0];
            K_JNP:   res_o.jump_taken = (nzc != 2'b00);
            K_JNN:   res_o.jump_taken = !flags_i[3];
            default: res_o.jump_taken = !flags_i[2];
          endcase
        end
        default: begin
          res_o.flags = flags_i;
        end
      endcase
    end
  end

endmodule

>>> rtl/aluf_muldiv.sv
// bit-serial unit: shift-add multiply and restoring signed divide
// depends on aluf_pkg
module aluf_muldiv import aluf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             div_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  input  logic             ack_i,
  output logic             done_o,
  output md_res_t          res_o
);

  logic                busy_q, busy_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DataW-1:0]    hi_q, hi_d, lo_q, lo_d, mc_q, mc_d, corr_q, corr_d;
  logic                div_q, div_d, qneg_q, qneg_d, rneg_q, rneg_d, ovf_q, ovf_d;
  logic [DataW-1:0]    abs_a, abs_b, hi_s;
  logic [DataW:0]      madd, shifted, dsub;
  logic                ge;

  assign abs_a   = a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b   = b_i[DataW-1] ? (~b_i + 1'b1) : b_i;
  // multiply step: add multiplicand when the low bit is set
  assign madd    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);
  // divide step: shift in the next dividend bit, trial subtract
  assign shifted = {hi_q, lo_q[DataW-1]};
  assign dsub    = shifted - {1'b0, mc_q};
  assign ge      = (shifted >= {1'b0, mc_q});
  assign done_o  = busy_q && (cnt_q == CntW'(DataW));
  assign hi_s    = hi_q - corr_q;

  // final sign fix and flags
  always_comb begin
    res_o.is_div = div_q;
    if (div_q) begin
      res_o.lo = qneg_q ? (~lo_q + 1'b1) : lo_q;
      res_o.hi = rneg_q ? (~hi_q + 1'b1) : hi_q;
      res_o.c  = ovf_q;
      res_o.v  = ovf_q;
    end else begin
      res_o.lo = lo_q;
      res_o.hi = hi_q;
      res_o.c  = |hi_q;
      res_o.v  = (hi_s != {DataW{lo_q[DataW-1]}});
    end
  end

  // load and iterate
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    mc_d   = mc_q;
    corr_d = corr_q;
    div_d  = div_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    ovf_d  = ovf_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hi_d   = '0;
      div_d  = div_i;
      lo_d   = div_i ? abs_a : b_i;
      mc_d   = div_i ? abs_b : a_i;
      corr_d = (a_i[DataW-1] ? b_i : '0) + (b_i[DataW-1] ? a_i : '0);
      qneg_d = a_i[DataW-1] ^ b_i[DataW-1];
      rneg_d = a_i[DataW-1];
      ovf_d  = (a_i == {1'b1, {(DataW-1){1'b0}}}) && (b_i == '1);
    end else if (done_o) begin
      if (ack_i) begin
        busy_d = 1'b0;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (div_q) begin
        hi_d = ge ? dsub[DataW-1:0] : shifted[DataW-1:0];
        lo_d = {lo_q[DataW-2:0], ge};
      end else begin
        hi_d = madd[DataW:1];
        lo_d = {madd[0], lo_q[DataW-1:1]};
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    mc_q   <= mc_d;
    corr_q <= corr_d;
    div_q  <= div_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
    ovf_q  <= ovf_d;
  end

endmodule

>>> rtl/alu_with_condition_flags.sv
// Integer ALU with N/Z/C/V flags, one instruction in flight at a time. MOV, ADD,
// SUB, CMP, logic, SWAP, shifts, LDL/LDH, NOT and jumps finish in the cycle of
// the input transfer and reach the output register in the next cycle. MUL and
// DIV run on a bit-serial unit that handles one operand bit per cycle (operands
// load on the transfer edge, 32 steps follow, then the result moves into the
// output register as soon as that register is free or being drained).
// A new item is taken when no MUL/DIV is running and the output register is
// free or being drained; flags update as each result enters the output register.
module alu_with_condition_flags import aluf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [4:0]       kind_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic             dest_immediate_i,
  input  logic             source_immediate_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] result_value_o,
  output logic [DataW-1:0] second_value_o,
  output logic             write_first_o,
  output logic             write_second_o,
  output logic             jump_taken_o,
  output logic [3:0]       flags_out_o,
  output logic [1:0]       fault_o
);

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  res_t    out_q, out_d, basic_res, md_item;
  logic [3:0] flags_q;
  logic    is_long, accept, slot_free, md_start, md_done, md_ack, load_out;
  md_res_t md_res;

  aluf_basic u_basic (
    .kind_i    (kind_i),
    .a_i       (operand_a_i),
    .b_i       (operand_b_i),
    .dimm_i    (dest_immediate_i),
    .simm_i    (source_immediate_i),
    .flags_i   (flags_q),
    .res_o     (basic_res),
    .is_long_o (is_long)
  );

  aluf_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .div_i   (kind_i == K_DIV),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .ack_i   (md_ack),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  // handshake
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign md_start   = accept && is_long;
  assign md_ack     = (state_q == ST_RUN) && md_done && slot_free;
  assign load_out   = (accept && !is_long) || md_ack;

  // result item from the serial unit
  always_comb begin
    md_item              = '0;
    md_item.result_value = md_res.lo;
    md_item.second_value = md_res.is_div ? md_res.hi : '0;
    md_item.write_first  = 1'b1;
    md_item.write_second = md_res.is_div;
    md_item.flags        = {nz_of(md_res.lo), md_res.c, md_res.v};
    md_item.fault        = FLT_NONE;
  end

  // next state and output register
  always_comb begin
    state_d     = state_q;
    out_d       = (state_q == ST_RUN) ? md_item : basic_res;
    out_valid_d = out_valid_q;
    unique case (state_q)
      ST_IDLE: if (md_start) state_d = ST_RUN;
      ST_RUN:  if (md_ack)   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        flags_q <= out_d.flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q.result_value;
  assign second_value_o = out_q.second_value;
  assign write_first_o  = out_q.write_first;
  assign write_second_o = out_q.write_second;
  assign jump_taken_o   = out_q.jump_taken;
  assign flags_out_o    = out_q.flags;
  assign fault_o        = out_q.fault;

endmodule

>>> rtl/aluf_checker.sv
// port-level checks for the alu with condition flags, bound to the top level
// depends on aluf_pkg and alu_with_condition_flags_defines.svh
`include "alu_with_condition_flags_defines.svh"

module aluf_checker import aluf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       write_first_o,
  input logic       write_second_o,
  input logic       jump_taken_o,
  input logic [3:0] flags_out_o,
  input logic [1:0] fault_o
);

  logic any_store;

  // either store enable
  assign any_store = write_first_o | write_second_o;

  // a faulting item writes nothing and takes no jump
  `ALUF_ASSERT_IMPL(a_fault_quiet, out_valid_o && fault_o != FLT_NONE, !any_store && !jump_taken_o)
  // a taken jump stores to neither operand
  `ALUF_ASSERT_IMPL(a_jump_nowrite, out_valid_o && jump_taken_o, !any_store)
  // a second store always comes with a first store
  `ALUF_ASSERT_IMPL(a_second_pair, out_valid_o && write_second_o, write_first_o)
  // a stalled result holds its flags
  `ALUF_ASSERT_NEXT(a_stall_flags, out_valid_o && out_stall_i, $stable(flags_out_o))

endmodule

bind alu_with_condition_flags aluf_checker u_aluf_checker (.*);

>>> sim/tb_alu_with_condition_flags.sv
// testbench for the alu with condition flags: directed and random instructions,
// each result checked against an in-bench flag and value predictor
// depends on aluf_pkg and alu_with_condition_flags
module tb_alu_with_condition_flags;
  import aluf_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] rv;
    logic [DataW-1:0] sv;
    logic             wf;
    logic             ws;
    logic             jt;
    logic [3:0]       fl;
    logic [1:0]       flt;
  } alu_out_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [4:0]       kind_i;
  logic [DataW-1:0] operand_a_i;
  logic [DataW-1:0] operand_b_i;
  logic             dest_immediate_i;
  logic             source_immediate_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [DataW-1:0] result_value_o;
  logic [DataW-1:0] second_value_o;
  logic             write_first_o;
  logic             write_second_o;
  logic             jump_taken_o;
  logic [3:0]       flags_out_o;
  logic [1:0]       fault_o;

  alu_out_t   expected_q[$];
  logic [3:0] model_flags;
  int         err_count;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_stall_pct;

  alu_with_condition_flags DUT (.*);

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // mismatch report
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  function automatic logic [3:0] nz_flags(input logic [31:0] r);
    return {r[31], r == 32'd0, 2'b00};
  endfunction

  // predicts one instruction and updates the flag state
  function automatic alu_out_t predict_alu(input logic [4:0] k, input logic [31:0] a,
                                           input logic [31:0] b, input logic dimm,
                                           input logic simm);
    alu_out_t o;
    logic [3:0]  f;
    logic [32:0] sum;
    logic [63:0] wide;
    logic signed [63:0] sp;
    logic [5:0]  n;
    logic [1:0]  nz;
    logic        t;
    o = '0;
    f = model_flags;
    t = 1'b0;
    n = (b > 32'd32) ? 6'd32 : b[5:0];
    if (k <= K_NOT && k != K_CMP && (dimm || (k == K_SWAP && simm))) begin
      o.flt = FLT_IMM;
    end else if (k == K_DIV && b == 32'd0) begin
      o.flt = FLT_DIV0;
    end else begin
      case (k)
        K_MOV: begin o.rv = b; o.wf = 1'b1; f = nz_flags(b); end
        K_ADD: begin
          sum = {1'b0, a} + {1'b0, b};
          o.rv = sum[31:0]; o.wf = 1'b1; f = nz_flags(o.rv);
          f[1] = sum[32];
          f[0] = (a[31] ^ o.rv[31]) & (b[31] ^ o.rv[31]);
        end
        K_SUB, K_CMP: begin
          o.rv = a - b; f = nz_flags(o.rv);
          f[1] = a < b;
          f[0] = (a[31] ^ b[31]) & (a[31] ^ o.rv[31]);
          if (k == K_SUB) o.wf = 1'b1; else o.rv = '0;
        end
        K_MUL: begin
          wide = {32'd0, a} * {32'd0, b};
          sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          o.rv = wide[31:0]; o.wf = 1'b1; f = nz_flags(o.rv);
          f[1] = wide[63:32] != 32'd0;
          f[0] = sp != $signed({{32{o.rv[31]}}, o.rv});
        end
        K_DIV: begin
          o.wf = 1'b1; o.ws = 1'b1;
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
            o.rv = a; f = nz_flags(a) | 4'b0011;
          end else begin
            o.rv = $signed(a) / $signed(b);
            o.sv = $signed(a) % $signed(b);
            f = nz_flags(o.rv);
          end
        end
        K_AND: begin o.rv = a & b; o.wf = 1'b1; f = nz_flags(o.rv); end
        K_OR:  begin o.rv = a | b; o.wf = 1'b1; f = nz_flags(o.rv); end
        K_XOR: begin o.rv = a ^ b; o.wf = 1'b1; f = nz_flags(o.rv); end
        K_SWAP: begin
          o.rv = b; o.sv = a; o.wf = 1'b1; o.ws = 1'b1; f = nz_flags(b);
        end
        K_SHL: begin
          wide = {32'd0, a} << n;
          o.rv = wide[31:0]; o.wf = 1'b1; f = nz_flags(o.rv);
          f[1] = wide[63:32] != 32'd0;
          f[0] = a[31] ^ o.rv[31];
        end
        K_SHR, K_SAR: begin
          wide = {a, 32'd0} >> n;
          if (k == K_SAR && a[31])
            wide = wide | ~({64{1'b1}} >> n);
          o.rv = wide[63:32]; o.wf = 1'b1; f = nz_flags(o.rv);
          f[1] = wide[31:0] != 32'd0;
        end
        K_LDL: begin o.rv = {a[31:16], b[15:0]}; o.wf = 1'b1; end
        K_LDH: begin o.rv = {b[15:0], a[15:0]}; o.wf = 1'b1; end
        K_NOT: begin o.rv = ~a; o.wf = 1'b1; f = nz_flags(o.rv); end
        K_JMP, K_JP, K_JN, K_JZ, K_JC, K_JV, K_JNP, K_JNN, K_JNZ: begin
          nz = f[3:2];
          case (k)
            K_JMP: t = 1'b1;
            K_JP:  t = nz == 2'b00;
            K_JN:  t = nz == 2'b10;
            K_JZ:  t = nz == 2'b01;
            K_JC:  t = f[1];
            K_JV:  t = f[0];
            K_JNP: t = nz != 2'b00;
            K_JNN: t = !f[3];
            default: t = !f[2];
          endcase
          o.rv = a; o.jt = t;
        end
        default: ;
      endcase
    end
    model_flags = f;
    o.fl = f;
    return o;
  endfunction

  // sends one instruction and queues its prediction on transfer
  task automatic send_instr(input logic [4:0] k, input logic [31:0] a,
                            input logic [31:0] b, input logic dimm, input logic simm);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1; kind_i = k; operand_a_i = a; operand_b_i = b;
    dest_immediate_i = dimm; source_immediate_i = simm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_alu(k, a, b, dimm, simm));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    alu_out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result_value_o, 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (result_value_o !== w.rv) report_mismatch("result_value", result_value_o, w.rv);
        if (second_value_o !== w.sv) report_mismatch("second_value", second_value_o, w.sv);
        if (write_first_o !== w.wf)
          report_mismatch("write_first", 32'(write_first_o), 32'(w.wf));
        if (write_second_o !== w.ws)
          report_mismatch("write_second", 32'(write_second_o), 32'(w.ws));
        if (jump_taken_o !== w.jt)
          report_mismatch("jump_taken", 32'(jump_taken_o), 32'(w.jt));
        if (flags_out_o !== w.fl)
          report_mismatch("flags_out", 32'(flags_out_o), 32'(w.fl));
        if (fault_o !== w.flt) report_mismatch("fault", 32'(fault_o), 32'(w.flt));
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] edge_value();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h1;
      5: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // extremes, each special case and every jump
  task automatic test_directed();
    send_instr(K_ADD, 32'hFFFF_FFFF, 32'h1, 1'b0, 1'b0);
    send_instr(K_ADD, 32'h7FFF_FFFF, 32'h1, 1'b0, 1'b0);
    send_instr(K_SUB, 32'h0, 32'h1, 1'b0, 1'b0);
    send_instr(K_CMP, 32'h8000_0000, 32'h1, 1'b1, 1'b0);
    send_instr(K_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_instr(K_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_instr(K_DIV, 32'hFFFF_FFF9, 32'h2, 1'b0, 1'b0);
    send_instr(K_DIV, 32'h5, 32'h0, 1'b0, 1'b0);
    send_instr(K_DIV, 32'h5, 32'h0, 1'b1, 1'b0);
    send_instr(K_SWAP, 32'h1234, 32'h5678, 1'b0, 1'b1);
    send_instr(K_SWAP, 32'hA5A5_A5A5, 32'h0, 1'b0, 1'b0);
    send_instr(K_SHL, 32'hC000_0001, 32'd33, 1'b0, 1'b0);
    send_instr(K_SHR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_instr(K_SAR, 32'h8000_0001, 32'd1, 1'b0, 1'b0);
    send_instr(K_LDL, 32'hFFFF_FFFF, 32'h0000_1234, 1'b0, 1'b0);
    send_instr(K_LDH, 32'h0, 32'hABCD_5678, 1'b0, 1'b0);
    send_instr(K_NOT, 32'h0, 32'h0, 1'b0, 1'b0);
    for (int k = K_JMP; k <= 31; k++) send_instr(k[4:0], $urandom, $urandom, 1'b1, 1'b1);
  endtask

  // random instructions, mostly well formed
  task automatic test_random(input int count);
    logic [4:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(24));
      if (i == count / 2) wait_drained();
      send_instr(k, edge_value(), edge_value(), $urandom_range(15) == 0,
                 $urandom_range(7) == 0);
    end
  endtask

  initial begin
    rst_ni = 1'b0; in_valid_i = 1'b0; kind_i = '0; operand_a_i = '0; operand_b_i = '0;
    dest_immediate_i = 1'b0; source_immediate_i = 1'b0; out_stall_i = 1'b0;
    err_count = 0; cycle_count = 0; model_flags = '0;
    send_idle_pct = 6; recv_stall_pct = 48;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(300);
    send_idle_pct = 48; recv_stall_pct = 6;
    test_random(300);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(330);
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
